FILE: rtl/icstk_pkg.sv
`timescale 1ns / 1ps

package icstk_pkg;

  localparam int DEPTH_DEF   = 64;
  localparam int FUNC_W      = 3;
  localparam int VALUE_W     = 8;
  localparam int POS_W       = 6;
  localparam int STATUS_W    = 2;
  localparam int LENGTH_W    = 7;
  localparam int IN_TDATA_W  = 24;
  localparam int OUT_TDATA_W = 24;

  localparam logic [FUNC_W-1:0] FN_PUSH    = 3'd0;
  localparam logic [FUNC_W-1:0] FN_INSERT  = 3'd1;
  localparam logic [FUNC_W-1:0] FN_REMOVE  = 3'd2;
  localparam logic [FUNC_W-1:0] FN_REVERSE = 3'd3;
  localparam logic [FUNC_W-1:0] FN_READ    = 3'd4;

  localparam logic [STATUS_W-1:0] ST_OK     = 2'd0;
  localparam logic [STATUS_W-1:0] ST_FULL   = 2'd1;
  localparam logic [STATUS_W-1:0] ST_EMPTY  = 2'd2;
  localparam logic [STATUS_W-1:0] ST_BADIDX = 2'd3;

  // controller to datapath
  typedef struct packed {
    logic load;
    logic eval;
    logic push;
    logic mv_init_ins;
    logic mv_init_rem;
    logic mv_rd;
    logic mv_wr;
    logic ins_fin;
    logic rem_fin;
    logic rv_init;
    logic rv_rdlo;
    logic rv_rdhi;
    logic rv_wrlo;
    logic rv_wrhi;
    logic rd_issue;
    logic post;
  } icstk_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic is_push;
    logic is_insert;
    logic is_remove;
    logic is_reverse;
    logic is_read;
    logic ok;
    logic mv_done;
    logic rv_done;
    logic out_free;
  } icstk_stat_t;

endpackage

FILE: rtl/icstk_datapath.sv
`timescale 1ns / 1ps

module icstk_datapath #(
  parameter int DEPTH = icstk_pkg::DEPTH_DEF
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic [icstk_pkg::IN_TDATA_W-1:0]    in_tdata,
  input  icstk_pkg::icstk_cmd_t               cmd,
  output icstk_pkg::icstk_stat_t              stat,
  output logic                                m_axis_tvalid,
  input  logic                                m_axis_tready,
  output logic [icstk_pkg::OUT_TDATA_W-1:0]   m_axis_tdata
);
  import icstk_pkg::*;

  localparam int AW    = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam int CMP_W = (CNT_W > POS_W) ? CNT_W : POS_W;

  logic [VALUE_W-1:0]  mem [DEPTH];

  logic [FUNC_W-1:0]   op_func;
  logic [VALUE_W-1:0]  op_value;
  logic [POS_W-1:0]    op_pos;
  logic [CNT_W-1:0]    count;
  logic [AW-1:0]       idx;
  logic [AW-1:0]       lo;
  logic [AW-1:0]       hi;
  logic [VALUE_W-1:0]  tmp;
  logic [VALUE_W-1:0]  rdata;
  logic [STATUS_W-1:0] stat_q;
  logic [STATUS_W-1:0] out_status;
  logic [LENGTH_W-1:0] out_length;
  logic [VALUE_W-1:0]  out_rbyte;

  logic [STATUS_W-1:0] stat_code;
  logic                full;
  logic                empty;
  logic                bad_idx;
  logic [AW-1:0]       pos_a;
  logic [AW-1:0]       cnt_a;
  logic                we;
  logic [AW-1:0]       waddr;
  logic [VALUE_W-1:0]  wdata;
  logic                re;
  logic [AW-1:0]       raddr;

  assign pos_a   = AW'(op_pos);
  assign cnt_a   = AW'(count);
  assign full    = (count >= CNT_W'(DEPTH));
  assign empty   = (count == '0);
  assign bad_idx = (CMP_W'(op_pos) >= CMP_W'(count));

  always_comb begin
    stat_code = ST_OK;
    if (op_func == FN_PUSH) begin
      if (full) stat_code = ST_FULL;
    end else if (op_func == FN_INSERT) begin
      if (full)         stat_code = ST_FULL;
      else if (bad_idx) stat_code = ST_BADIDX;
    end else if (op_func == FN_REMOVE || op_func == FN_READ) begin
      if (empty)        stat_code = ST_EMPTY;
      else if (bad_idx) stat_code = ST_BADIDX;
    end
  end

  assign stat.is_push    = (op_func == FN_PUSH);
  assign stat.is_insert  = (op_func == FN_INSERT);
  assign stat.is_remove  = (op_func == FN_REMOVE);
  assign stat.is_reverse = (op_func == FN_REVERSE);
  assign stat.is_read    = (op_func == FN_READ);
  assign stat.ok         = (stat_code == ST_OK);
  // insert walks down to pos, remove walks up to the top
  assign stat.mv_done    = (op_func == FN_INSERT) ? (idx == pos_a)
                         : ((CNT_W'(idx) + CNT_W'(1)) >= count);
  assign stat.rv_done    = (lo >= hi);
  assign stat.out_free   = !m_axis_tvalid || m_axis_tready;

  // write port
  always_comb begin
    we    = 1'b0;
    waddr = idx;
    wdata = rdata;
    unique if (cmd.push) begin
      we    = 1'b1;
      waddr = cnt_a;
      wdata = op_value;
    end else if (cmd.ins_fin) begin
      we    = 1'b1;
      waddr = pos_a;
      wdata = op_value;
    end else if (cmd.mv_wr) begin
      we    = 1'b1;
      waddr = idx;
      wdata = rdata;
    end else if (cmd.rv_wrlo) begin
      we    = 1'b1;
      waddr = lo;
      wdata = rdata;
    end else if (cmd.rv_wrhi) begin
      we    = 1'b1;
      waddr = hi;
      wdata = tmp;
    end else begin
      we    = 1'b0;
    end
  end

  // read port
  always_comb begin
    re    = 1'b0;
    raddr = idx;
    unique if (cmd.mv_rd) begin
      re    = 1'b1;
      raddr = (op_func == FN_INSERT) ? (idx - AW'(1)) : (idx + AW'(1));
    end else if (cmd.rv_rdlo) begin
      re    = 1'b1;
      raddr = lo;
    end else if (cmd.rv_rdhi) begin
      re    = 1'b1;
      raddr = hi;
    end else if (cmd.rd_issue) begin
      re    = 1'b1;
      raddr = pos_a;
    end else begin
      re    = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    if (re) rdata <= mem[raddr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count         <= '0;
      m_axis_tvalid <= 1'b0;
    end else begin
      if (cmd.push || cmd.ins_fin) count <= count + CNT_W'(1);
      else if (cmd.rem_fin)        count <= count - CNT_W'(1);
      if (cmd.post)                m_axis_tvalid <= 1'b1;
      else if (m_axis_tready)      m_axis_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op_func  <= in_tdata[FUNC_W-1:0];
      op_value <= in_tdata[FUNC_W +: VALUE_W];
      op_pos   <= in_tdata[FUNC_W+VALUE_W +: POS_W];
    end
    if (cmd.eval) stat_q <= stat_code;
    if (cmd.mv_init_ins)      idx <= cnt_a;
    else if (cmd.mv_init_rem) idx <= pos_a;
    else if (cmd.mv_wr)       idx <= (op_func == FN_INSERT) ? (idx - AW'(1)) : (idx + AW'(1));
    if (cmd.rv_init) begin
      lo <= '0;
      hi <= empty ? '0 : AW'(count - CNT_W'(1));
    end else if (cmd.rv_wrhi) begin
      lo <= lo + AW'(1);
      hi <= hi - AW'(1);
    end
    if (cmd.rv_rdhi) tmp <= rdata;
    if (cmd.post) begin
      out_status <= stat_q;
      out_length <= LENGTH_W'(count);
      out_rbyte  <= (op_func == FN_READ && stat_q == ST_OK) ? rdata : '0;
    end
  end

  assign m_axis_tdata = {{(OUT_TDATA_W - STATUS_W - LENGTH_W - VALUE_W){1'b0}},
                         out_rbyte, out_length, out_status};

endmodule

FILE: rtl/icstk_ctrl.sv
`timescale 1ns / 1ps

module icstk_ctrl (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    s_axis_tvalid,
  output logic                    s_axis_tready,
  input  icstk_pkg::icstk_stat_t  stat,
  output icstk_pkg::icstk_cmd_t   cmd
);
  import icstk_pkg::*;

  typedef enum logic [9:0] {
    S_IDLE    = 10'b0000000001,
    S_EXEC    = 10'b0000000010,
    S_MV_CHK  = 10'b0000000100,
    S_MV_WR   = 10'b0000001000,
    S_RV_CHK  = 10'b0000010000,
    S_RV_RDHI = 10'b0000100000,
    S_RV_WRLO = 10'b0001000000,
    S_RV_WRHI = 10'b0010000000,
    S_RD_WAIT = 10'b0100000000,
    S_DONE    = 10'b1000000000
  } state_t;

  state_t state;
  state_t state_next;

  assign s_axis_tready = (state == S_IDLE);

  always_comb begin
    state_next = state;
    cmd        = '0;
    unique case (state)
      S_IDLE: begin
        if (s_axis_tvalid) begin
          cmd.load   = 1'b1;
          state_next = S_EXEC;
        end
      end
      S_EXEC: begin
        cmd.eval = 1'b1;
        priority if (!stat.ok) begin
          state_next = S_DONE;
        end else if (stat.is_push) begin
          cmd.push   = 1'b1;
          state_next = S_DONE;
        end else if (stat.is_insert) begin
          cmd.mv_init_ins = 1'b1;
          state_next      = S_MV_CHK;
        end else if (stat.is_remove) begin
          cmd.mv_init_rem = 1'b1;
          state_next      = S_MV_CHK;
        end else if (stat.is_reverse) begin
          cmd.rv_init = 1'b1;
          state_next  = S_RV_CHK;
        end else if (stat.is_read) begin
          cmd.rd_issue = 1'b1;
          state_next   = S_RD_WAIT;
        end else begin
          state_next = S_DONE;
        end
      end
      S_MV_CHK: begin
        if (stat.mv_done) begin
          if (stat.is_insert) cmd.ins_fin = 1'b1;
          else                cmd.rem_fin = 1'b1;
          state_next = S_DONE;
        end else begin
          cmd.mv_rd  = 1'b1;
          state_next = S_MV_WR;
        end
      end
      S_MV_WR: begin
        cmd.mv_wr  = 1'b1;
        state_next = S_MV_CHK;
      end
      // swap one pair: read low, read high, write low, write high
      S_RV_CHK: begin
        if (stat.rv_done) begin
          state_next = S_DONE;
        end else begin
          cmd.rv_rdlo = 1'b1;
          state_next  = S_RV_RDHI;
        end
      end
      S_RV_RDHI: begin
        cmd.rv_rdhi = 1'b1;
        state_next  = S_RV_WRLO;
      end
      S_RV_WRLO: begin
        cmd.rv_wrlo = 1'b1;
        state_next  = S_RV_WRHI;
      end
      S_RV_WRHI: begin
        cmd.rv_wrhi = 1'b1;
        state_next  = S_RV_CHK;
      end
      S_RD_WAIT: begin
        state_next = S_DONE;
      end
      S_DONE: begin
        if (stat.out_free) begin
          cmd.post   = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) state <= S_IDLE;
    else     state <= state_next;
  end

endmodule

FILE: rtl/indexed_char_stack.sv
`timescale 1ns / 1ps
// one operation at a time through a single-port-write, single-port-read byte memory
// a new word is accepted only once the result of the last one has been posted; push, errors,
// unused codes and read do no memory moves; insert and remove move one byte per step between
// position and the top of the stack, and reverse swaps one pair per step from both ends inward
// the result is registered and may stall in its register until taken
// synchronous reset empties the stack and drops any pending result; memory is not cleared
module indexed_char_stack #(
  parameter int DEPTH = icstk_pkg::DEPTH_DEF
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               s_axis_tvalid,
  output logic                               s_axis_tready,
  // func[2:0], value[10:3], position[16:11], zero fill above
  input  logic [icstk_pkg::IN_TDATA_W-1:0]   s_axis_tdata,
  output logic                               m_axis_tvalid,
  input  logic                               m_axis_tready,
  // status[1:0], length[8:2], read_byte[16:9], zero fill above
  output logic [icstk_pkg::OUT_TDATA_W-1:0]  m_axis_tdata
);
  import icstk_pkg::*;

  icstk_cmd_t  cmd;
  icstk_stat_t stat;

  icstk_ctrl u_ctrl (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .stat          (stat),
    .cmd           (cmd)
  );

  icstk_datapath #(
    .DEPTH (DEPTH)
  ) u_dp (
    .clk           (clk),
    .rst           (rst),
    .in_tdata      (s_axis_tdata),
    .cmd           (cmd),
    .stat          (stat),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

endmodule

FILE: rtl/icstk_checker.sv
`timescale 1ns / 1ps

module icstk_checker #(
  parameter int DEPTH = icstk_pkg::DEPTH_DEF
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               m_axis_tvalid,
  input  logic                               m_axis_tready,
  input  logic [icstk_pkg::OUT_TDATA_W-1:0]  m_axis_tdata
);
  import icstk_pkg::*;

  logic [STATUS_W-1:0] status;
  logic [LENGTH_W-1:0] length;
  logic [VALUE_W-1:0]  read_byte;

  assign status    = m_axis_tdata[STATUS_W-1:0];
  assign length    = m_axis_tdata[STATUS_W +: LENGTH_W];
  assign read_byte = m_axis_tdata[STATUS_W+LENGTH_W +: VALUE_W];

  a_reset_clears: assert property (@(posedge clk) rst |=> !m_axis_tvalid)
    else $error("result valid right after reset");

  // a stalled word stays put until it is taken
  a_hold_stalled: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("stalled result changed or dropped");

  a_full_len: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && status == ST_FULL |-> length == LENGTH_W'(DEPTH))
    else $error("full status with length below depth");

  a_empty_len: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && status == ST_EMPTY |-> length == '0)
    else $error("empty status with nonzero length");

  a_byte_zero: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && status != ST_OK |-> read_byte == '0)
    else $error("read byte set on a failed operation");

endmodule

bind indexed_char_stack icstk_checker #(
  .DEPTH (DEPTH)
) u_icstk_checker (
  .clk           (clk),
  .rst           (rst),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata)
);
